FILE: rtl/core/gma3d_pkg.sv
// gma3d_pkg: shared constants and types for the 3-D grid cell-center averager.
// No dependencies; compiled first.
package gma3d_pkg;

   // Default sizes handed to the top-level parameters
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int MAX_X_DEF       = 256;
   localparam int MAX_Y_DEF       = 256;

   // CSR port geometry
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register field widths and reset values
   localparam int PX_BITS = 9;
   localparam int PY_BITS = 9;
   localparam int PZ_BITS = 16;
   localparam logic [PX_BITS-1:0] PX_RESET = 9'd256;
   localparam logic [PY_BITS-1:0] PY_RESET = 9'd256;
   localparam logic [PZ_BITS-1:0] PZ_RESET = 16'd256;

   // Register word index (byte address / 4)
   typedef enum logic [1:0] {
      REG_POINTS_X = 2'd0,
      REG_POINTS_Y = 2'd1,
      REG_POINTS_Z = 2'd2
   } csr_index_type;

endpackage

FILE: rtl/core/gma3d_req_if.sv
// gma3d_req_if: input sample channel (valid/ready plus one grid sample).
// Depends on gma3d_pkg for the default sample width.
interface gma3d_req_if #(
   parameter int SAMPLE_BITS = gma3d_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/gma3d_rsp_if.sv
// gma3d_rsp_if: result channel (valid/ready plus cell-center value and volume-end flag).
// Depends on gma3d_pkg for the default sample width.
interface gma3d_rsp_if #(
   parameter int SAMPLE_BITS = gma3d_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] mid_value;
   logic                          last_of_volume;

   modport source (output valid, output mid_value, output last_of_volume, input ready);
   modport sink   (input valid, input mid_value, input last_of_volume, output ready);
endinterface

FILE: rtl/core/grid_to_midpoint_average_3d_core.sv
// Cell-center averager for a raster-ordered 3-D grid: row store, plane store and pipeline.
// Depends on gma3d_pkg, gma3d_req_if and gma3d_rsp_if.
//
// Usage
//   req_ch carries one grid sample per transfer, x fastest, then y, then z, volumes repeating.
//   rsp_ch carries one cell-center value (floor of the mean of its eight corners) for every
//   sample that closes a cell, i.e. with x, y and z positions all nonzero; other samples
//   give nothing. last_of_volume marks the final cell of a volume.
//   The APB port holds points_x (0x0), points_y (0x4) and points_z (0x8). Any write to
//   these restarts the raster at point (0,0,0); write only while the block is idle.
// Timing
//   A closing sample is registered in the middle stage, then its result in the output register.
//   Throughput is one sample per cycle unless rsp_ch stalls: a sample with nonzero x makes one
//   row-store read and write at accept; if y is also nonzero, one plane-store read at accept
//   and a write from the middle stage. Both stores are single-write, single-read memories.
// Reset and stalls
//   Synchronous reset empties the pipeline and returns the raster to (0,0,0); the stores
//   need no clearing, since only entries written earlier in the volume are used.
//   While rsp_ch is stalled the result register holds; samples that close no cell pass on,
//   the next closing sample waits in the middle stage and req_ch.ready drops until it moves.
module grid_to_midpoint_average_3d_core #(
   parameter int MAX_X       = gma3d_pkg::MAX_X_DEF,
   parameter int MAX_Y       = gma3d_pkg::MAX_Y_DEF,
   parameter int SAMPLE_BITS = gma3d_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   gma3d_req_if.sink                             req_ch,
   gma3d_rsp_if.source                           rsp_ch,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [gma3d_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [gma3d_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [gma3d_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                  pready
);
   import gma3d_pkg::*;

   localparam int XW    = $clog2(MAX_X);
   localparam int YW    = $clog2(MAX_Y);
   localparam int PW    = $clog2(MAX_X * MAX_Y);
   localparam int SB    = SAMPLE_BITS;
   localparam int PAIRW = SB + 1;
   localparam int QUADW = SB + 2;
   localparam int SUMW  = SB + 3;

   // Configuration registers
   logic [PX_BITS-1:0] points_x_ff;
   logic [PY_BITS-1:0] points_y_ff;
   logic [PZ_BITS-1:0] points_z_ff;

   // Raster position and previous sample
   logic [XW-1:0]      pos_x_ff, pos_x_in;
   logic [YW-1:0]      pos_y_ff, pos_y_in;
   logic [PZ_BITS-1:0] pos_z_ff, pos_z_in;
   logic signed [SB-1:0] prev_ff;

   // Stores
   logic signed [PAIRW-1:0] row_mem   [MAX_X];
   logic signed [QUADW-1:0] plane_mem [MAX_X * MAX_Y];
   logic signed [PAIRW-1:0] row_rd_ff;
   logic signed [QUADW-1:0] plane_rd_ff;

   // Middle stage
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_res_ff;
   logic                    s1_plane_wr_ff;
   logic                    s1_last_ff;
   logic [PW-1:0]           s1_addr_ff;
   logic signed [PAIRW-1:0] s1_pair_ff;

   // Output stage
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]    mid_ff;
   logic                    last_ff;

   // Combinational
   logic [XW-1:0]           x_last;
   logic [YW-1:0]           y_last;
   logic [PZ_BITS-1:0]      z_last;
   logic                    x_wrap, y_wrap, z_wrap;
   logic                    has_x, has_y, has_z;
   logic [XW-1:0]           cx;
   logic [YW-1:0]           cy;
   logic [PW-1:0]           plane_addr;
   logic signed [PAIRW-1:0] pair_c;
   logic signed [QUADW-1:0] quad_c;
   logic signed [SUMW-1:0]  sum_c;
   logic                    acc, s1_go, s2_free, cfg_wr, restart;
   csr_index_type           csr_idx;

   // ---------------------------------------------------------------- CSR port
   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[3:2]);
   assign cfg_wr  = psel && penable && pwrite;

   always_comb begin
      restart = 1'b0;
      case (csr_idx)
         REG_POINTS_X, REG_POINTS_Y, REG_POINTS_Z: restart = cfg_wr;
         default:                                  restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_x_ff <= PX_RESET;
         points_y_ff <= PY_RESET;
         points_z_ff <= PZ_RESET;
      end else if (cfg_wr) begin
         case (csr_idx)
            REG_POINTS_X: points_x_ff <= pwdata[PX_BITS-1:0];
            REG_POINTS_Y: points_y_ff <= pwdata[PY_BITS-1:0];
            REG_POINTS_Z: points_z_ff <= pwdata[PZ_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_POINTS_X: prdata = CSR_DATA_BITS'(points_x_ff);
         REG_POINTS_Y: prdata = CSR_DATA_BITS'(points_y_ff);
         REG_POINTS_Z: prdata = CSR_DATA_BITS'(points_z_ff);
         default:      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- clamped extents
   always_comb begin
      if (points_x_ff < PX_BITS'(2))        x_last = XW'(1);
      else if (int'(points_x_ff) > MAX_X)   x_last = XW'(MAX_X - 1);
      else                                  x_last = XW'(points_x_ff - 1'b1);

      if (points_y_ff < PY_BITS'(2))        y_last = YW'(1);
      else if (int'(points_y_ff) > MAX_Y)   y_last = YW'(MAX_Y - 1);
      else                                  y_last = YW'(points_y_ff - 1'b1);

      if (points_z_ff < PZ_BITS'(2))        z_last = PZ_BITS'(1);
      else                                  z_last = points_z_ff - 1'b1;
   end

   // ---------------------------------------------------------------- handshake
   assign s2_free      = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && (!s1_res_ff || s2_free);
   assign req_ch.ready = !reset && (!s1_valid_ff || s1_go);
   assign acc          = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------------- raster position
   assign x_wrap = (pos_x_ff == x_last);
   assign y_wrap = (pos_y_ff == y_last);
   assign z_wrap = (pos_z_ff == z_last);
   assign has_x  = (pos_x_ff != '0);
   assign has_y  = (pos_y_ff != '0);
   assign has_z  = (pos_z_ff != '0);

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (restart) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
      end else if (acc) begin
         pos_x_in = x_wrap ? '0 : pos_x_ff + 1'b1;
         if (x_wrap) begin
            pos_y_in = y_wrap ? '0 : pos_y_ff + 1'b1;
            if (y_wrap) pos_z_in = z_wrap ? '0 : pos_z_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         prev_ff  <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         if (acc) prev_ff <= req_ch.sample;
      end
   end

   // ---------------------------------------------------------------- store addressing
   assign cx         = pos_x_ff - 1'b1;
   assign cy         = pos_y_ff - 1'b1;
   assign plane_addr = PW'(int'(cy) * MAX_X + int'(cx));
   assign pair_c     = PAIRW'(prev_ff) + PAIRW'(req_ch.sample);

   // Row store: pair sums of the previous row, read old value and write new at accept
   always_ff @(posedge clock) begin
      if (acc && has_x) begin
         row_mem[cx] <= pair_c;
         row_rd_ff   <= row_mem[cx];
      end
   end

   // Plane store: read at accept, written back from the middle stage
   always_ff @(posedge clock) begin
      if (s1_go && s1_plane_wr_ff) plane_mem[s1_addr_ff] <= quad_c;
      if (acc && has_x && has_y)   plane_rd_ff <= plane_mem[plane_addr];
   end

   // ---------------------------------------------------------------- middle stage
   assign s1_valid_in = acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_res_ff      <= has_x && has_y && has_z;
         s1_plane_wr_ff <= has_x && has_y;
         s1_last_ff     <= x_wrap && y_wrap && z_wrap;
         s1_addr_ff     <= plane_addr;
         s1_pair_ff     <= pair_c;
      end
   end

   // quad = row pair + this pair; sum of eight = plane quad + quad
   assign quad_c = QUADW'(row_rd_ff) + QUADW'(s1_pair_ff);
   assign sum_c  = SUMW'(plane_rd_ff) + SUMW'(quad_c);

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_res_ff) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // arithmetic shift by 3 floors toward minus infinity
   always_ff @(posedge clock) begin
      if (s1_go && s1_res_ff) begin
         mid_ff  <= sum_c[SUMW-1:3];
         last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.mid_value      = mid_ff;
   assign rsp_ch.last_of_volume = last_ff;

endmodule

FILE: rtl/core/gma3d_checker.sv
// gma3d_checker: port-level assertions for the cell-center averager, plus its bind.
// Depends on gma3d_pkg and binds into grid_to_midpoint_average_3d_core.
module gma3d_checker #(
   parameter int SAMPLE_BITS = gma3d_pkg::SAMPLE_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_mid_value,
   input logic                   rsp_last_of_volume
);
   import gma3d_pkg::*;

   // A stalled result keeps its valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mid_value)
                                  && $stable(rsp_last_of_volume))
      else $error("result changed while stalled");

   // Reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // An idle output only wakes once a transferred sample has passed through the middle stage
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a sample transfer two cycles earlier");

   // No sample is taken during reset
   a_req_reset: assert property (@(posedge clock)
      reset |-> !req_ready)
      else $error("input ready during reset");

endmodule

bind grid_to_midpoint_average_3d_core gma3d_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_gma3d_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_mid_value      (rsp_ch.mid_value),
   .rsp_last_of_volume (rsp_ch.last_of_volume)
);
